// ===== rtl/websocket_frame_deframer_top_defines.svh =====
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define WSFD_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define WSFD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
// types, constants and helpers shared by the websocket frame deframer
`timescale 1ns / 1ps

package wsfd_pkg;

   // default sizes
   localparam int WSFD_LENGTH_BITS = 64;
   localparam int WSFD_QUEUE_DEPTH = 4;

   // reset value of the payload limit register
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

   // frame opcodes
   localparam logic [3:0] OPCODE_CONT  = 4'h0;
   localparam logic [3:0] OPCODE_TEXT  = 4'h1;
   localparam logic [3:0] OPCODE_CLOSE = 4'h8;

   // 7-bit length codes that announce an extended length
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // header layout
   localparam logic [3:0] HDR_BASE_BYTES = 4'd2;
   localparam logic [3:0] KEY_BYTES      = 4'd4;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_7,
      KIND_16,
      KIND_64
   } length_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_CONT_EXPECTED,
      ERR_TOO_LARGE
   } error_type;

   // input beat
   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_payload;
      logic [3:0] message_type;
      logic       end_of_frame;
      logic       end_of_message;
      error_type  error_code;
      logic       now_closed;
   } rsp_type;

   // entry handed from the parser to the output side
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       has_payload;
      logic [3:0] message_type;
      logic       end_of_frame;
      logic       end_of_message;
      error_type  error_code;
      logic       now_closed;
   } work_type;

   // number of extended length bytes for a length kind
   function automatic logic [3:0] length_bytes(input length_kind_type kind);
      logic [3:0] n;
      case (kind)
         KIND_16: n = 4'd2;
         KIND_64: n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/wsfd_front.sv =====
// header parser and payload tracker: turns each accepted byte into at most one entry
`timescale 1ns / 1ps

module wsfd_front #(
   parameter int LENGTH_BITS = wsfd_pkg::WSFD_LENGTH_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              accept,
   input  wsfd_pkg::req_type req_data,
   output logic              push_valid,
   output wsfd_pkg::work_type push_data
);
   import wsfd_pkg::*;

   localparam int CMP_BITS = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   // state
   logic [31:0]            max_ff;
   logic [3:0]             hdr_ff, hdr_in;
   logic                   fin_ff, fin_in;
   logic                   masked_ff, masked_in;
   length_kind_type        kind_ff, kind_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [7:0]             key_ff [4];
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   in_payload_ff, in_payload_in;
   logic [3:0]             msg_type_ff, msg_type_in;
   logic                   frag_ff, frag_in;
   logic                   started_ff, started_in;
   logic                   closed_ff, closed_in;

   // header decode
   logic [7:0]             b;
   logic                   masked_new;
   length_kind_type        kind_new;
   logic [LENGTH_BITS-1:0] len_new;
   logic [LENGTH_BITS-1:0] len_shift;
   logic [3:0]             hdr_next;
   logic [3:0]             hlen;
   logic                   hdr_done;
   logic                   len_too_big;
   logic                   in_len_bytes;
   logic [1:0]             key_idx;
   logic                   key_we;
   logic [LENGTH_BITS-1:0] count_inc;

   // action flags
   logic                   do_end;
   logic [7:0]             end_byte;
   logic                   end_has;
   logic                   do_fail;
   error_type              fail_code;
   logic                   closing;

   assign b = req_data.rx_byte;

   // next length byte, saturating at all ones
   assign len_shift = (|len_ff[LENGTH_BITS-1 -: 8]) ? '1 : {len_ff[LENGTH_BITS-9:0], b};

   assign in_len_bytes = hdr_ff < (HDR_BASE_BYTES + length_bytes(kind_ff));
   assign key_idx      = (kind_ff == KIND_16) ? hdr_ff[1:0] : hdr_ff[1:0] + 2'd2;

   // fields of the header byte at the current offset
   always_comb begin
      masked_new = masked_ff;
      kind_new   = kind_ff;
      len_new    = len_ff;
      if (hdr_ff == 4'd1) begin
         masked_new = b[7];
         if (b[6:0] == LEN_CODE_16) begin
            kind_new = KIND_16;
            len_new  = '0;
         end else if (b[6:0] == LEN_CODE_64) begin
            kind_new = KIND_64;
            len_new  = '0;
         end else begin
            kind_new = KIND_7;
            len_new  = {{(LENGTH_BITS-7){1'b0}}, b[6:0]};
         end
      end else if (in_len_bytes) begin
         len_new = len_shift;
      end
   end

   assign hdr_next    = hdr_ff + 4'd1;
   assign hlen        = HDR_BASE_BYTES + length_bytes(kind_new) + (masked_new ? KEY_BYTES : 4'd0);
   assign hdr_done    = hdr_next >= hlen;
   assign len_too_big = CMP_BITS'(len_new) > CMP_BITS'(max_ff);
   assign count_inc   = count_ff + 1'b1;
   assign closing     = fin_ff && (msg_type_ff == OPCODE_CLOSE);

   // per-byte state update and entry generation
   always_comb begin
      hdr_in        = hdr_ff;
      fin_in        = fin_ff;
      masked_in     = masked_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      in_payload_in = in_payload_ff;
      msg_type_in   = msg_type_ff;
      frag_in       = frag_ff;
      started_in    = started_ff;
      closed_in     = closed_ff;
      key_we        = 1'b0;
      do_end        = 1'b0;
      end_byte      = 8'd0;
      end_has       = 1'b0;
      do_fail       = 1'b0;
      fail_code     = ERR_NONE;
      push_valid    = 1'b0;
      push_data     = '{data: 8'd0, key: 8'd0, has_payload: 1'b0,
                        message_type: msg_type_ff, end_of_frame: 1'b0,
                        end_of_message: 1'b0, error_code: ERR_NONE,
                        now_closed: 1'b0};

      if (accept && !req_data.command && !closed_ff) begin
         if (in_payload_ff) begin
            // payload byte: unmasking happens on the output side
            count_in               = count_inc;
            push_valid             = 1'b1;
            push_data.data         = b;
            push_data.key          = masked_ff ? key_ff[count_ff[1:0]] : 8'd0;
            push_data.has_payload  = 1'b1;
            if (count_inc >= len_ff) begin
               do_end   = 1'b1;
               end_byte = b;
               end_has  = 1'b1;
            end
         end else if (hdr_ff == 4'd0) begin
            // first header byte: fin and opcode, fragment tracking
            fin_in = b[7];
            if (!started_ff) begin
               frag_in     = !b[7];
               msg_type_in = b[3:0];
               started_in  = 1'b1;
               hdr_in      = 4'd1;
            end else if (frag_ff && (b[3:0] != OPCODE_CONT)) begin
               do_fail   = 1'b1;
               fail_code = ERR_CONT_EXPECTED;
            end else begin
               started_in = 1'b1;
               hdr_in     = 4'd1;
            end
         end else begin
            // length and key bytes
            masked_in = masked_new;
            kind_in   = kind_new;
            len_in    = len_new;
            key_we    = (hdr_ff != 4'd1) && !in_len_bytes;
            hdr_in    = hdr_next;
            if (hdr_done) begin
               if (len_too_big) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_TOO_LARGE;
               end else if (len_new == '0) begin
                  do_end = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end
      end

      // error result closes the link
      if (do_fail) begin
         closed_in            = 1'b1;
         push_valid           = 1'b1;
         push_data.error_code = fail_code;
         push_data.now_closed = 1'b1;
      end

      // last result of a frame
      if (do_end) begin
         push_valid               = 1'b1;
         push_data.data           = end_byte;
         push_data.has_payload    = end_has;
         push_data.end_of_frame   = 1'b1;
         push_data.end_of_message = fin_ff;
         push_data.now_closed     = closing;
         if (fin_ff) begin
            msg_type_in = OPCODE_TEXT;
            frag_in     = 1'b0;
            started_in  = 1'b0;
         end
         hdr_in        = 4'd0;
         fin_in        = 1'b0;
         masked_in     = 1'b0;
         kind_in       = KIND_NONE;
         len_in        = '0;
         count_in      = '0;
         in_payload_in = 1'b0;
         if (closing) begin
            closed_in = 1'b1;
         end
      end

      // reopen clears all parse state
      if (accept && req_data.command) begin
         hdr_in        = 4'd0;
         fin_in        = 1'b0;
         masked_in     = 1'b0;
         kind_in       = KIND_NONE;
         len_in        = '0;
         count_in      = '0;
         in_payload_in = 1'b0;
         msg_type_in   = OPCODE_TEXT;
         frag_in       = 1'b0;
         started_in    = 1'b0;
         closed_in     = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff        <= MAX_PAYLOAD_RESET;
         hdr_ff        <= 4'd0;
         fin_ff        <= 1'b0;
         masked_ff     <= 1'b0;
         kind_ff       <= KIND_NONE;
         len_ff        <= '0;
         count_ff      <= '0;
         in_payload_ff <= 1'b0;
         msg_type_ff   <= OPCODE_TEXT;
         frag_ff       <= 1'b0;
         started_ff    <= 1'b0;
         closed_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         hdr_ff        <= hdr_in;
         fin_ff        <= fin_in;
         masked_ff     <= masked_in;
         kind_ff       <= kind_in;
         len_ff        <= len_in;
         count_ff      <= count_in;
         in_payload_ff <= in_payload_in;
         msg_type_ff   <= msg_type_in;
         frag_ff       <= frag_in;
         started_ff    <= started_in;
         closed_ff     <= closed_in;
      end
   end

   // masking key bytes
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[key_idx] <= b;
      end
   end

endmodule

// ===== rtl/wsfd_queue.sv =====
// short queue of parsed entries between the parser and the output side
`timescale 1ns / 1ps

module wsfd_queue #(
   parameter int DEPTH = wsfd_pkg::WSFD_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsfd_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output wsfd_pkg::work_type pop_data,
   output logic               empty
);
   import wsfd_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   work_type              entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = count_ff == COUNT_BITS'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/wsfd_back.sv =====
// output side: unmasks queued entries into the result register
`timescale 1ns / 1ps

module wsfd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  wsfd_pkg::work_type q_data,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output wsfd_pkg::rsp_type  rsp_data
);
   import wsfd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load;

   // refill the result register when it is free or being taken
   assign load  = !q_empty && (!valid_ff || pop);
   assign q_pop = load;

   always_comb begin
      valid_in = load || (valid_ff && !pop);
      rsp_in   = rsp_ff;
      if (load) begin
         rsp_in.payload_byte   = q_data.data ^ q_data.key;
         rsp_in.has_payload    = q_data.has_payload;
         rsp_in.message_type   = q_data.message_type;
         rsp_in.end_of_frame   = q_data.end_of_frame;
         rsp_in.end_of_message = q_data.end_of_message;
         rsp_in.error_code     = q_data.error_code;
         rsp_in.now_closed     = q_data.now_closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// Websocket frame deframer: takes one received byte per cycle (push/full) while
// full is low, parses the frame header, and delivers unmasked payload bytes,
// zero-length frame markers and error results as beats on the result side
// (empty/pop). While full is low a new byte is taken every cycle; the per-byte
// work is one header/payload state update in the parser, whose widest path is the
// payload count increment and compare against the frame length. A result is
// written into the entry queue at the edge that accepts its byte, and moves on
// into the output register, from which it can be popped, once that register is
// free or being popped. full rises only when the entry queue (QUEUE_DEPTH
// entries) has filled because results are not being popped. The payload limit
// register may be written only while idle.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top #(
   parameter int LENGTH_BITS = wsfd_pkg::WSFD_LENGTH_BITS,
   parameter int QUEUE_DEPTH = wsfd_pkg::WSFD_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  wsfd_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output wsfd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import wsfd_pkg::*;

   logic     accept;
   logic     push_valid;
   work_type push_entry;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   work_type q_data;

   assign full   = q_full;
   assign accept = push && !q_full;

   // parser
   wsfd_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_data    (req_data),
      .push_valid  (push_valid),
      .push_data   (push_entry)
   );

   // entry queue
   wsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // unmask and result register
   wsfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // checks
   `WSFD_ASSERT_NOW(a_no_push_when_full, clock, reset, push_valid, !q_full,
                    "entry pushed into a full queue")
   `WSFD_ASSERT_NEXT(a_result_loads, clock, reset, !q_empty && empty, !empty,
                     "queued entry not moved to result register")
   `WSFD_ASSERT_NOW(a_error_closes, clock, reset,
                    !empty && (rsp_data.error_code != ERR_NONE),
                    rsp_data.now_closed && !rsp_data.end_of_frame && !rsp_data.has_payload,
                    "error result with wrong marks")
   `WSFD_ASSERT_NOW(a_eom_needs_eof, clock, reset, !empty && rsp_data.end_of_message,
                    rsp_data.end_of_frame, "end of message without end of frame")

endmodule
